### hdl/red_pkg.sv
package red_pkg;

   // Event codes carried in the result beat and held in the event store
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_LEFT    = 3'd1,
      EV_RIGHT   = 3'd2,
      EV_PRESS   = 3'd3,
      EV_RELEASE = 3'd4,
      EV_LONG    = 3'd5
   } event_code_type;

   // Debounced AB phase codes kept in the phase history
   typedef enum logic [2:0] {
      PH_EMPTY = 3'd0,
      PH_A1B0  = 3'd1,
      PH_A0B1  = 3'd2,
      PH_A1B1  = 3'd3,
      PH_A0B0  = 3'd4
   } phase_type;

   // Request kinds (req_tuser)
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_GET    = 1'b1
   } op_type;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSE_DIRECTION = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS  = 8'd1;

   localparam int unsigned TIMER_WIDTH      = 16;
   localparam logic [TIMER_WIDTH-1:0] LONG_PRESS_RESET = 16'd1024;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX        = 16'hFFFF;

   // event store holds QUEUE_LIMIT+1 entries; the count field is sized for it
   localparam int unsigned QUEUE_LIMIT     = 16;
   localparam int unsigned COUNT_OUT_WIDTH = 5;

endpackage

### hdl/red_vote.sv
// One debounced pin: shift window plus majority vote on the updated window.
module red_vote #(
   parameter int WINDOW = 5
) (
   input  logic clock,
   input  logic reset,
   input  logic sample,
   input  logic level,
   output logic vote
);
   localparam int OW = $clog2(WINDOW + 1);
   localparam logic [OW-1:0] THRESHOLD = OW'((WINDOW + 1) / 2);

   logic [WINDOW-1:0] window_ff;
   logic [WINDOW-1:0] window_in;
   logic [WINDOW:0]   shifted;
   logic [OW-1:0]     ones;

   assign shifted   = {window_ff, level};
   assign window_in = shifted[WINDOW-1:0];

   always_comb begin
      ones = '0;
      for (int i = 0; i < WINDOW; i++) begin
         ones = ones + OW'(window_in[i]);
      end
   end

   // ties with an even window vote high
   assign vote = (ones >= THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '1;
      end else if (sample) begin
         window_ff <= window_in;
      end
   end

endmodule

### hdl/rotary_encoder_button_decoder_unit.sv
// An accepted req beat passes the input register, then the result register,
// to become the matching rsp beat. Throughput: one req beat per cycle unless
// rsp_tready stalls a held result; state is updated in the same cycle as the
// result register, so back-to-back beats see each other's effects.
// Reset (synchronous, active high): pipeline empty, debounce windows released,
// phase history empty, event count zero, config back to defaults.
module rotary_encoder_button_decoder_unit #(
   parameter int DEBOUNCE_WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] clk_level, [1] dt_level, [2] sw_level, rest zero
   input  logic        req_tuser,   // [0] op

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] event_code, [7:3] queue_count, [8] dropped

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [red_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [red_pkg::TIMER_WIDTH-1:0]     csr_data
);
   import red_pkg::*;

   // store holds QUEUE_LIMIT+1 events, newest on top
   localparam int DEPTH = QUEUE_LIMIT + 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);

   // ---------------- config registers ----------------
   logic                   reverse_ff;
   logic [TIMER_WIDTH-1:0] long_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff    <= 1'b0;
         long_ticks_ff <= LONG_PRESS_RESET;
      end else if (csr_valid) begin
         // unknown indexes are dropped
         if (csr_index == CSR_REVERSE_DIRECTION) begin
            reverse_ff <= csr_data[0];
         end else if (csr_index == CSR_LONG_PRESS_TICKS) begin
            long_ticks_ff <= csr_data;
         end
      end
   end

   // ---------------- input register ----------------
   logic       in_valid_ff;
   op_type     in_op_ff;
   logic [2:0] in_pins_ff;     // {sw, dt, clk}
   logic       advance;
   logic       out_valid_ff;

   // a beat moves into the result register when that register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= op_type'(req_tuser);
         in_pins_ff <= req_tdata[2:0];
      end
   end

   // ---------------- debouncers ----------------
   logic sample;
   logic a_vote, b_vote, sw_vote;

   assign sample = advance && (in_op_ff == OP_SAMPLE);

   red_vote #(.WINDOW(DEBOUNCE_WINDOW)) u_vote_a (
      .clock (clock), .reset (reset), .sample (sample),
      .level (in_pins_ff[0]), .vote (a_vote)
   );
   red_vote #(.WINDOW(DEBOUNCE_WINDOW)) u_vote_b (
      .clock (clock), .reset (reset), .sample (sample),
      .level (in_pins_ff[1]), .vote (b_vote)
   );
   red_vote #(.WINDOW(DEBOUNCE_WINDOW)) u_vote_sw (
      .clock (clock), .reset (reset), .sample (sample),
      .level (in_pins_ff[2]), .vote (sw_vote)
   );

   // ---------------- decoder state ----------------
   logic                   last_sw_ff,  last_sw_in;
   logic                   ignore_ff,   ignore_in;
   logic [TIMER_WIDTH-1:0] timer_ff,    timer_in;
   phase_type              hist_ff [4];
   phase_type              hist_in [4];
   logic [CW-1:0]          count_ff,    count_in;

   event_code_type         store_ff [DEPTH];
   logic                   store_we;
   logic                   store_shift;
   logic [IW-1:0]          store_widx;
   logic [IW-1:0]          store_ridx;
   logic [CW-1:0]          count_dec;

   event_code_type         ev;
   logic                   drop;
   phase_type              ph;
   logic [TIMER_WIDTH-1:0] timer_inc;

   assign count_dec  = count_ff - 1'b1;
   assign store_ridx = count_dec[IW-1:0];

   always_comb begin
      last_sw_in  = last_sw_ff;
      ignore_in   = ignore_ff;
      timer_in    = timer_ff;
      hist_in     = hist_ff;
      count_in    = count_ff;
      ev          = EV_NONE;
      drop        = 1'b0;
      store_we    = 1'b0;
      store_shift = 1'b0;
      store_widx  = count_ff[IW-1:0];
      ph          = PH_A0B0;
      timer_inc   = (timer_ff != TIMER_MAX) ? timer_ff + 1'b1 : timer_ff;

      if (advance) begin
         if (in_op_ff == OP_GET) begin
            // pop newest; empty store gives no event
            if (count_ff != '0) begin
               count_in = count_dec;
               ev       = store_ff[store_ridx];
            end
         end else begin
            // button: press, release (muted after long press), repeating long press
            priority if (!sw_vote && last_sw_ff) begin
               timer_in = '0;
               ev       = EV_PRESS;
            end else if (sw_vote && !last_sw_ff) begin
               if (!ignore_ff) begin
                  ev = EV_RELEASE;
               end
               ignore_in = 1'b0;
            end else if (!sw_vote && !last_sw_ff) begin
               timer_in = timer_inc;
               if (timer_inc > long_ticks_ff) begin
                  ignore_in = 1'b1;
                  ev        = EV_LONG;
                  timer_in  = '0;
               end
            end else begin
               timer_in = timer_ff;
            end

            unique case ({a_vote, b_vote})
               2'b10:   ph = PH_A1B0;
               2'b01:   ph = PH_A0B1;
               2'b11:   ph = PH_A1B1;
               default: ph = PH_A0B0;
            endcase

            // button events take priority over history updates
            if (ev == EV_NONE && hist_ff[3] != ph) begin
               hist_in[0] = hist_ff[1];
               hist_in[1] = hist_ff[2];
               hist_in[2] = hist_ff[3];
               hist_in[3] = ph;
            end
            last_sw_in = sw_vote;

            // full detent sequences; a match overrides any button event
            if (hist_in[0] == PH_A0B1 && hist_in[1] == PH_A0B0 &&
                hist_in[2] == PH_A1B0 && hist_in[3] == PH_A1B1) begin
               hist_in = '{default: PH_EMPTY};
               ev      = reverse_ff ? EV_RIGHT : EV_LEFT;
            end else if (hist_in[0] == PH_A1B0 && hist_in[1] == PH_A0B0 &&
                         hist_in[2] == PH_A0B1 && hist_in[3] == PH_A1B1) begin
               hist_in = '{default: PH_EMPTY};
               ev      = reverse_ff ? EV_LEFT : EV_RIGHT;
            end

            // push; a full store drops its oldest entry
            if (ev != EV_NONE) begin
               if (count_ff == CW'(DEPTH)) begin
                  store_shift = 1'b1;
                  drop        = 1'b1;
               end else begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sw_ff <= 1'b1;
         ignore_ff  <= 1'b0;
         timer_ff   <= '0;
         hist_ff    <= '{default: PH_EMPTY};
         count_ff   <= '0;
      end else begin
         last_sw_ff <= last_sw_in;
         ignore_ff  <= ignore_in;
         timer_ff   <= timer_in;
         hist_ff    <= hist_in;
         count_ff   <= count_in;
      end
   end

   // event store: contents are not reset, the count tells what is valid
   always_ff @(posedge clock) begin
      if (store_shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[DEPTH-1] <= ev;
      end else if (store_we) begin
         store_ff[store_widx] <= ev;
      end
   end

   // ---------------- result register ----------------
   event_code_type             out_code_ff;
   logic [COUNT_OUT_WIDTH-1:0] out_count_ff;
   logic                       out_drop_ff;
   logic [31:0]                count_wide;

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_code_ff  <= ev;
         out_count_ff <= count_wide[COUNT_OUT_WIDTH-1:0];
         out_drop_ff  <= drop;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_drop_ff, out_count_ff, out_code_ff};

endmodule

### hdl/red_checker.sv
module red_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import red_pkg::*;

   // only defined event codes leave the block
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= EV_LONG))
      else $error("event code out of range");

   // a drop only happens on a push, which always carries an event
   a_drop_has_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> (rsp_tdata[2:0] != EV_NONE))
      else $error("drop flagged without an event");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

endmodule

bind rotary_encoder_button_decoder_unit red_checker u_red_checker (.*);

### tb/rotary_encoder_button_decoder_unit_tb.sv
`timescale 1ns / 1ps

module rotary_encoder_button_decoder_unit_tb;
   import red_pkg::*;

   localparam int DB_WIN      = 5;                // debounce window of the instance
   localparam int STORE_DEPTH = QUEUE_LIMIT + 1;  // event store entries
   localparam int STALL_LIMIT = 1000;             // cycles without any handshake
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 8'hFF;

   // One pending request beat
   typedef struct packed {
      op_type op;
      logic   clk_l;
      logic   dt_l;
      logic   sw_l;
   } pin_beat_t;

   // One predicted rsp beat
   typedef struct {
      event_code_type code;
      logic [COUNT_OUT_WIDTH-1:0] count;
      logic dropped;
   } event_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] clk_level, [1] dt_level, [2] sw_level, rest zero
   logic        req_tuser  = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [2:0] event_code, [7:3] queue_count, [8] dropped
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [TIMER_WIDTH-1:0]     csr_data  = '0;

   rotary_encoder_button_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Decoder mirror: config copy plus the block's state
   // ---------------------------------------------------------------
   logic                   swap_dir;
   logic [TIMER_WIDTH-1:0] lp_ticks;
   logic [DB_WIN-1:0]      pin_win [3];      // 0 clk, 1 dt, 2 sw
   logic                   prev_sw;
   logic                   mute_release;
   logic [TIMER_WIDTH-1:0] held_ticks;
   phase_type              ph_hist [4];
   event_code_type         ev_store [STORE_DEPTH];
   logic [COUNT_OUT_WIDTH-1:0] ev_count;

   // Testbench bookkeeping
   pin_beat_t     pin_beats_q[$];
   event_result_t event_results_q[$];
   int results_owed = 0;   // beats queued whose rsp has not been checked
   int errors       = 0;
   int req_gap      = 0;
   int rsp_gap      = 0;
   int stall_cycles = 0;
   bit calm         = 1'b0; // no idling on either side when set

   task automatic clear_mirror();
      swap_dir     = 1'b0;
      lp_ticks     = LONG_PRESS_RESET;
      for (int i = 0; i < 3; i++) pin_win[i] = '1;
      prev_sw      = 1'b1;
      mute_release = 1'b0;
      held_ticks   = '0;
      for (int i = 0; i < 4; i++) ph_hist[i] = PH_EMPTY;
      for (int i = 0; i < STORE_DEPTH; i++) ev_store[i] = EV_NONE;
      ev_count     = '0;
   endtask

   // Shift one raw sample into a pin's window and vote
   function automatic logic vote_pin(input int pin, input logic lvl);
      logic [DB_WIN-1:0] w;
      w = {pin_win[pin][DB_WIN-2:0], lvl};
      pin_win[pin] = w;
      return ($countones(w) * 2 >= DB_WIN);
   endfunction

   task automatic step_decoder(input pin_beat_t b, output event_result_t r);
      event_code_type ev;
      logic drop;
      logic a, bb, sw;
      phase_type ph;
      ev   = EV_NONE;
      drop = 1'b0;
      if (b.op == OP_GET) begin
         // pop newest; empty store leaves everything alone
         if (ev_count > 0) begin
            ev_count = ev_count - 1'b1;
            ev = ev_store[ev_count];
         end
      end else begin
         a  = vote_pin(0, b.clk_l);
         bb = vote_pin(1, b.dt_l);
         sw = vote_pin(2, b.sw_l);

         if (!sw && prev_sw) begin
            held_ticks = '0;
            ev = EV_PRESS;
         end else if (sw && !prev_sw) begin
            if (!mute_release) ev = EV_RELEASE;
            mute_release = 1'b0;
         end else if (!sw && !prev_sw) begin
            if (held_ticks < TIMER_MAX) held_ticks = held_ticks + 1'b1;
            if (held_ticks > lp_ticks) begin
               mute_release = 1'b1;
               ev = EV_LONG;
               held_ticks = '0;
            end
         end

         // button event wins the tick: history frozen
         if (ev == EV_NONE) begin
            if (a && !bb)      ph = PH_A1B0;
            else if (!a && bb) ph = PH_A0B1;
            else if (a && bb)  ph = PH_A1B1;
            else               ph = PH_A0B0;
            if (ph_hist[3] != ph) begin
               ph_hist[0] = ph_hist[1];
               ph_hist[1] = ph_hist[2];
               ph_hist[2] = ph_hist[3];
               ph_hist[3] = ph;
            end
         end
         prev_sw = sw;

         if (ph_hist[0] == PH_A0B1 && ph_hist[1] == PH_A0B0 &&
             ph_hist[2] == PH_A1B0 && ph_hist[3] == PH_A1B1) begin
            for (int i = 0; i < 4; i++) ph_hist[i] = PH_EMPTY;
            ev = swap_dir ? EV_RIGHT : EV_LEFT;
         end else if (ph_hist[0] == PH_A1B0 && ph_hist[1] == PH_A0B0 &&
                      ph_hist[2] == PH_A0B1 && ph_hist[3] == PH_A1B1) begin
            for (int i = 0; i < 4; i++) ph_hist[i] = PH_EMPTY;
            ev = swap_dir ? EV_LEFT : EV_RIGHT;
         end

         if (ev != EV_NONE) begin
            // full store: oldest entry falls off the bottom
            if (ev_count >= STORE_DEPTH) begin
               for (int i = 0; i < STORE_DEPTH - 1; i++) ev_store[i] = ev_store[i+1];
               ev_count = COUNT_OUT_WIDTH'(STORE_DEPTH - 1);
               drop = 1'b1;
            end
            ev_store[ev_count] = ev;
            ev_count = ev_count + 1'b1;
         end
      end
      r.code    = ev;
      r.count   = ev_count;
      r.dropped = drop;
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------
   // Driver: predicts on each accepted beat, then presents the next one
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      pin_beat_t     nxt;
      event_result_t res;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_decoder('{op: op_type'(req_tuser), clk_l: req_tdata[0],
                           dt_l: req_tdata[1], sw_l: req_tdata[2]}, res);
            event_results_q = {event_results_q, res};
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pin_beats_q.size() > 0) begin
               nxt = pin_beats_q[0];
               pin_beats_q.delete(0);
               req_tdata  <= {5'b0, nxt.sw_l, nxt.dt_l, nxt.clk_l};
               req_tuser  <= nxt.op;
               req_tvalid <= 1'b1;
               // gap opens once this beat is taken
               if (!calm && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks rsp beats in order, stalls in random bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      event_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (event_results_q.size() == 0) begin
               flag_mismatch("unexpected rsp beat", rsp_tdata, -1);
            end else begin
               want = event_results_q[0];
               event_results_q.delete(0);
               if (rsp_tdata[2:0] !== want.code)
                  flag_mismatch("event_code", rsp_tdata[2:0], want.code);
               if (rsp_tdata[7:3] !== want.count)
                  flag_mismatch("queue_count", rsp_tdata[7:3], want.count);
               if (rsp_tdata[8] !== want.dropped)
                  flag_mismatch("dropped", rsp_tdata[8], want.dropped);
               results_owed--;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 10);
         end
      end
   end

   // Watchdog: any handshake resets the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic enqueue_beat(input pin_beat_t b);
      pin_beats_q = {pin_beats_q, b};
      results_owed++;
   endtask

   task automatic push_tick(input logic a, input logic b, input logic sw);
      enqueue_beat('{op: OP_SAMPLE, clk_l: a, dt_l: b, sw_l: sw});
   endtask

   // pins are don't-care on a get, so randomize them
   task automatic push_get();
      enqueue_beat('{op: OP_GET, clk_l: $urandom_range(0, 1),
                     dt_l: $urandom_range(0, 1), sw_l: $urandom_range(0, 1)});
   endtask

   // One detent: four AB phases, each held min_hold..6 ticks, occasional glitch.
   // A hold of 2 can lose the phase in the vote, giving a broken sequence.
   task automatic queue_rotation(input bit to_left, input int min_hold);
      logic [1:0] seq [4];   // {A, B}
      logic [2:0] pins;      // {sw, B, A}
      int hold;
      if (to_left) seq = '{2'b01, 2'b00, 2'b10, 2'b11};
      else         seq = '{2'b10, 2'b00, 2'b01, 2'b11};
      for (int s = 0; s < 4; s++) begin
         hold = $urandom_range(min_hold, 6);
         for (int h = 0; h < hold; h++) begin
            pins = {1'b1, seq[s][0], seq[s][1]};
            if ($urandom_range(0, 9) == 0) pins[$urandom_range(0, 2)] ^= 1'b1;
            push_tick(pins[0], pins[1], pins[2]);
         end
      end
   endtask

   // Switch held low for 'hold' ticks then released for 3..6 ticks
   task automatic queue_press(input int hold);
      logic a, b;
      int rel;
      a = 1'b1;
      b = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, 1);
         b = $urandom_range(0, 1);
      end
      rel = $urandom_range(3, 6);
      repeat (hold) push_tick(a, b, 1'b0);
      repeat (rel) push_tick(a, b, 1'b1);
   endtask

   task automatic queue_random_burst();
      int pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         queue_rotation($urandom_range(0, 1), 2);
      end else if (pick < 60) begin
         queue_press($urandom_range(3, 40));
      end else if (pick < 85) begin
         n = $urandom_range(1, 5);
         repeat (n) push_get();
      end else begin
         // raw noise on all pins
         n = $urandom_range(1, 6);
         repeat (n) push_tick($urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1));
      end
   endtask

   // Config write, then an idle wait with valid low so valid never toggles in one step
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [TIMER_WIDTH-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_REVERSE_DIRECTION)     swap_dir = val[0];
      else if (idx == CSR_LONG_PRESS_TICKS) lp_ticks = val;
      @(posedge clock);
   endtask

   // Wait until every queued beat has its rsp checked, plus pipeline slack
   task automatic drain();
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int mark;
      clear_mirror();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset config: get on empty, slow left detent,
      // short press and release, then two gets and one more sample tick.
      push_get();
      queue_rotation(1'b1, 3);
      queue_press(3);
      push_get();
      push_get();
      push_tick(1'b0, 1'b0, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin
               // extremes: reversed, long press unreachable; bogus index ignored
               write_csr(CSR_REVERSE_DIRECTION, 16'd1);
               write_csr(CSR_LONG_PRESS_TICKS, TIMER_MAX);
               write_csr(CSR_UNUSED_INDEX, 16'(($urandom)));
            end
            1: begin
               // zero: long press on every held tick, drives store overflow
               write_csr(CSR_REVERSE_DIRECTION, 16'd0);
               write_csr(CSR_LONG_PRESS_TICKS, 16'd0);
            end
            2: begin
               write_csr(CSR_REVERSE_DIRECTION, 16'hFFFF);
               write_csr(CSR_LONG_PRESS_TICKS, 16'd1);
            end
            3: begin
               write_csr(CSR_REVERSE_DIRECTION, 16'd0);
               write_csr(CSR_LONG_PRESS_TICKS, 16'($urandom_range(2, 40)));
            end
            4: begin
               write_csr(CSR_REVERSE_DIRECTION, 16'd1);
               write_csr(CSR_LONG_PRESS_TICKS, 16'($urandom_range(1, 30)));
            end
            default: begin
               write_csr(CSR_REVERSE_DIRECTION, 16'd0);
               write_csr(CSR_LONG_PRESS_TICKS, 16'($urandom_range(3, 20)));
               calm = 1'b1;
            end
         endcase
         mark = results_owed;
         while (results_owed - mark < 125) queue_random_burst();
      end

      drain();
      repeat (10) @(posedge clock);
      if (event_results_q.size() != 0)
         flag_mismatch("rsp beats never arrived", 0, event_results_q.size());

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
